/* hdl/tbw_pkg.sv */
// Shared types, widths and helper functions of the triangle barycentric weight block.
package tbw_pkg;

   // Field widths of the items and registers.
   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 16;
   localparam int OUT_BITS   = 24;
   localparam int NUM_AXES   = 3;
   localparam int VERT_W     = NUM_AXES * COORD_BITS;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_A = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_B = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_C = 2'd2;

   // Datapath widths, all derived from the coordinate and fraction widths.
   localparam int DIFF_W = COORD_BITS + 1;
   localparam int PP_W   = 2 * DIFF_W;
   localparam int DOT_W  = PP_W + 2;
   localparam int LO_W   = DOT_W / 2;
   localparam int HI_W   = DOT_W - LO_W;
   localparam int PROD_W = 2 * DOT_W;
   localparam int NUM_W  = PROD_W + 1;
   localparam int NQ_W   = NUM_W + FRAC_BITS;
   localparam int QS_W   = NQ_W + 1;
   localparam int U_W    = QS_W + 2;

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;

   // Fixed point constants of the result stage.
   localparam logic signed [U_W-1:0] WEIGHT_ONE = U_W'(1) << FRAC_BITS;
   localparam logic signed [U_W-1:0] SAT_MAX    = U_W'((2 ** (OUT_BITS - 1)) - 1);
   localparam logic signed [U_W-1:0] SAT_MIN    = ~SAT_MAX;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
      logic signed [COORD_BITS-1:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] weight_u;
      logic signed [OUT_BITS-1:0] weight_v;
      logic signed [OUT_BITS-1:0] weight_w;
      logic                       degenerate;
   } rsp_type;

   // Dot products of one item, handed from the front to the back.
   typedef struct packed {
      logic signed [DOT_W-1:0] d00;
      logic signed [DOT_W-1:0] d01;
      logic signed [DOT_W-1:0] d11;
      logic signed [DOT_W-1:0] d20;
      logic signed [DOT_W-1:0] d21;
   } dots_type;

   // Clamp a wide signed weight to the output range.
   function automatic logic signed [OUT_BITS-1:0] sat_out(input logic signed [U_W-1:0] x);
      logic signed [OUT_BITS-1:0] r;
      if (x > SAT_MAX) begin
         r = SAT_MAX[OUT_BITS-1:0];
      end else if (x < SAT_MIN) begin
         r = SAT_MIN[OUT_BITS-1:0];
      end else begin
         r = x[OUT_BITS-1:0];
      end
      return r;
   endfunction

endpackage

/* hdl/tbw_front.sv */
// Front pipeline: accepts points, forms edge vectors and the five dot products.
module tbw_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  tbw_pkg::req_type               req_data,
   input  logic [tbw_pkg::VERT_W-1:0]     vertex_a,
   input  logic [tbw_pkg::VERT_W-1:0]     vertex_b,
   input  logic [tbw_pkg::VERT_W-1:0]     vertex_c,
   output logic                           q_push,
   output tbw_pkg::dots_type              q_data,
   input  logic                           q_full
);
   import tbw_pkg::*;

   logic front_en;

   logic signed [COORD_BITS-1:0] pt [NUM_AXES];

   logic                     f1_valid_ff, f1_valid_in;
   logic signed [DIFF_W-1:0] e0_ff [NUM_AXES];
   logic signed [DIFF_W-1:0] e1_ff [NUM_AXES];
   logic signed [DIFF_W-1:0] p_ff  [NUM_AXES];
   logic signed [DIFF_W-1:0] e0_in [NUM_AXES];
   logic signed [DIFF_W-1:0] e1_in [NUM_AXES];
   logic signed [DIFF_W-1:0] p_in  [NUM_AXES];

   logic                   f2_valid_ff, f2_valid_in;
   logic signed [PP_W-1:0] sq0_ff [NUM_AXES];
   logic signed [PP_W-1:0] x01_ff [NUM_AXES];
   logic signed [PP_W-1:0] sq1_ff [NUM_AXES];
   logic signed [PP_W-1:0] pe0_ff [NUM_AXES];
   logic signed [PP_W-1:0] pe1_ff [NUM_AXES];
   logic signed [PP_W-1:0] sq0_in [NUM_AXES];
   logic signed [PP_W-1:0] x01_in [NUM_AXES];
   logic signed [PP_W-1:0] sq1_in [NUM_AXES];
   logic signed [PP_W-1:0] pe0_in [NUM_AXES];
   logic signed [PP_W-1:0] pe1_in [NUM_AXES];

   logic     f3_valid_ff, f3_valid_in;
   dots_type dots_ff, dots_in;

   // The whole front advances together unless the last stage is blocked by a full queue.
   assign front_en  = !f3_valid_ff || !q_full;
   assign req_stall = !front_en;
   assign q_push    = f3_valid_ff && front_en;
   assign q_data    = dots_ff;

   assign pt[0] = req_data.point_x;
   assign pt[1] = req_data.point_y;
   assign pt[2] = req_data.point_z;

   // Stage 1: edge vectors and the point relative to vertex A.
   always_comb begin
      f1_valid_in = req_valid;
      for (int k = 0; k < NUM_AXES; k++) begin
         e0_in[k] = DIFF_W'($signed(vertex_b[k*COORD_BITS +: COORD_BITS]))
                  - DIFF_W'($signed(vertex_a[k*COORD_BITS +: COORD_BITS]));
         e1_in[k] = DIFF_W'($signed(vertex_c[k*COORD_BITS +: COORD_BITS]))
                  - DIFF_W'($signed(vertex_a[k*COORD_BITS +: COORD_BITS]));
         p_in[k]  = DIFF_W'(pt[k])
                  - DIFF_W'($signed(vertex_a[k*COORD_BITS +: COORD_BITS]));
      end
   end

   // Stage 2: per-axis products.
   always_comb begin
      f2_valid_in = f1_valid_ff;
      for (int k = 0; k < NUM_AXES; k++) begin
         sq0_in[k] = e0_ff[k] * e0_ff[k];
         x01_in[k] = e0_ff[k] * e1_ff[k];
         sq1_in[k] = e1_ff[k] * e1_ff[k];
         pe0_in[k] = p_ff[k] * e0_ff[k];
         pe1_in[k] = p_ff[k] * e1_ff[k];
      end
   end

   // Stage 3: sum the axes into the dot products.
   always_comb begin
      f3_valid_in = f2_valid_ff;
      dots_in.d00 = DOT_W'(sq0_ff[0]) + DOT_W'(sq0_ff[1]) + DOT_W'(sq0_ff[2]);
      dots_in.d01 = DOT_W'(x01_ff[0]) + DOT_W'(x01_ff[1]) + DOT_W'(x01_ff[2]);
      dots_in.d11 = DOT_W'(sq1_ff[0]) + DOT_W'(sq1_ff[1]) + DOT_W'(sq1_ff[2]);
      dots_in.d20 = DOT_W'(pe0_ff[0]) + DOT_W'(pe0_ff[1]) + DOT_W'(pe0_ff[2]);
      dots_in.d21 = DOT_W'(pe1_ff[0]) + DOT_W'(pe1_ff[1]) + DOT_W'(pe1_ff[2]);
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
      end else if (front_en) begin
         f1_valid_ff <= f1_valid_in;
         f2_valid_ff <= f2_valid_in;
         f3_valid_ff <= f3_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (front_en) begin
         for (int k = 0; k < NUM_AXES; k++) begin
            e0_ff[k]  <= e0_in[k];
            e1_ff[k]  <= e1_in[k];
            p_ff[k]   <= p_in[k];
            sq0_ff[k] <= sq0_in[k];
            x01_ff[k] <= x01_in[k];
            sq1_ff[k] <= sq1_in[k];
            pe0_ff[k] <= pe0_in[k];
            pe1_ff[k] <= pe1_in[k];
         end
         dots_ff <= dots_in;
      end
   end

endmodule

/* hdl/tbw_queue.sv */
// Short queue of dot-product items between the front and the back.
module tbw_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tbw_pkg::dots_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output tbw_pkg::dots_type pop_data
);
   import tbw_pkg::*;

   dots_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]     count_ff, count_in;

   assign full      = count_ff == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_data  = entry_ff[rd_ptr_ff];

   // Pointer and fill count update; the depth is a power of two so pointers wrap.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hdl/tbw_back.sv */
// Back pipeline: wide products, determinant, bit-per-stage division and saturation.
module tbw_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  tbw_pkg::dots_type q_data,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tbw_pkg::rsp_type  rsp_data
);
   import tbw_pkg::*;

   // Operand pairs of the six wide products.
   localparam int NUM_PAIRS  = 6;
   localparam int PR_D00_D11 = 0;
   localparam int PR_D01_D01 = 1;
   localparam int PR_D11_D20 = 2;
   localparam int PR_D01_D21 = 3;
   localparam int PR_D00_D21 = 4;
   localparam int PR_D01_D20 = 5;

   logic back_en;

   logic signed [DOT_W-1:0] op_a [NUM_PAIRS];
   logic signed [DOT_W-1:0] op_b [NUM_PAIRS];

   logic                           b1_valid_ff;
   logic signed [2*HI_W-1:0]       hh_ff [NUM_PAIRS];
   logic signed [HI_W+LO_W:0]      hl_ff [NUM_PAIRS];
   logic signed [HI_W+LO_W:0]      lh_ff [NUM_PAIRS];
   logic        [2*LO_W-1:0]       ll_ff [NUM_PAIRS];
   logic signed [2*HI_W-1:0]       hh_in [NUM_PAIRS];
   logic signed [HI_W+LO_W:0]      hl_in [NUM_PAIRS];
   logic signed [HI_W+LO_W:0]      lh_in [NUM_PAIRS];
   logic        [2*LO_W-1:0]       ll_in [NUM_PAIRS];

   logic                     b2_valid_ff;
   logic signed [PROD_W-1:0] prod_ff [NUM_PAIRS];
   logic signed [PROD_W-1:0] prod_in [NUM_PAIRS];

   logic                    b3_valid_ff;
   logic signed [NUM_W-1:0] den_ff, den_in;
   logic signed [NUM_W-1:0] nv_ff, nv_in;
   logic signed [NUM_W-1:0] nw_ff, nw_in;

   // Division pipeline; index 0 is loaded from the determinant stage.
   logic              dv_valid_ff [NQ_W+1];
   logic              dv_degen_ff [NQ_W+1];
   logic              dv_vneg_ff  [NQ_W+1];
   logic              dv_wneg_ff  [NQ_W+1];
   logic [NUM_W-1:0]  dv_den_ff   [NQ_W+1];
   logic [NUM_W-1:0]  dv_remv_ff  [NQ_W+1];
   logic [NUM_W-1:0]  dv_remw_ff  [NQ_W+1];
   logic [NQ_W-1:0]   dv_numv_ff  [NQ_W+1];
   logic [NQ_W-1:0]   dv_numw_ff  [NQ_W+1];

   logic              div_degen_in, div_vneg_in, div_wneg_in;
   logic [NUM_W-1:0]  magv_in, magw_in;

   logic                   s1_valid_ff;
   logic                   s1_degen_ff;
   logic signed [QS_W-1:0] v_ff, v_in;
   logic signed [QS_W-1:0] w_ff, w_in;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;
   logic signed [U_W-1:0] u_full;

   // The back moves as one whenever the output register is free or being emptied.
   assign back_en   = !rsp_valid_ff || !rsp_stall;
   assign q_pop     = q_valid && back_en;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Operand selection for the wide products.
   always_comb begin
      op_a[PR_D00_D11] = q_data.d00;  op_b[PR_D00_D11] = q_data.d11;
      op_a[PR_D01_D01] = q_data.d01;  op_b[PR_D01_D01] = q_data.d01;
      op_a[PR_D11_D20] = q_data.d11;  op_b[PR_D11_D20] = q_data.d20;
      op_a[PR_D01_D21] = q_data.d01;  op_b[PR_D01_D21] = q_data.d21;
      op_a[PR_D00_D21] = q_data.d00;  op_b[PR_D00_D21] = q_data.d21;
      op_a[PR_D01_D20] = q_data.d01;  op_b[PR_D01_D20] = q_data.d20;
   end

   // Stage 1: split each product into four half-width partial products.
   always_comb begin
      for (int i = 0; i < NUM_PAIRS; i++) begin
         hh_in[i] = $signed(op_a[i][DOT_W-1:LO_W]) * $signed(op_b[i][DOT_W-1:LO_W]);
         hl_in[i] = $signed(op_a[i][DOT_W-1:LO_W]) * $signed({1'b0, op_b[i][LO_W-1:0]});
         lh_in[i] = $signed({1'b0, op_a[i][LO_W-1:0]}) * $signed(op_b[i][DOT_W-1:LO_W]);
         ll_in[i] = op_a[i][LO_W-1:0] * op_b[i][LO_W-1:0];
      end
   end

   // Stage 2: recombine the partial products.
   always_comb begin
      for (int i = 0; i < NUM_PAIRS; i++) begin
         prod_in[i] = (PROD_W'(hh_ff[i]) <<< (2 * LO_W))
                    + (PROD_W'(hl_ff[i]) <<< LO_W)
                    + (PROD_W'(lh_ff[i]) <<< LO_W)
                    + PROD_W'(ll_ff[i]);
      end
   end

   // Stage 3: determinant and the two numerators.
   always_comb begin
      den_in = NUM_W'(prod_ff[PR_D00_D11]) - NUM_W'(prod_ff[PR_D01_D01]);
      nv_in  = NUM_W'(prod_ff[PR_D11_D20]) - NUM_W'(prod_ff[PR_D01_D21]);
      nw_in  = NUM_W'(prod_ff[PR_D00_D21]) - NUM_W'(prod_ff[PR_D01_D20]);
   end

   // Stage 4: signs and magnitudes that enter the divider.
   always_comb begin
      div_degen_in = den_ff[NUM_W-1] || (den_ff == '0);
      div_vneg_in  = nv_ff[NUM_W-1];
      div_wneg_in  = nw_ff[NUM_W-1];
      magv_in      = div_vneg_in ? NUM_W'(-nv_ff) : NUM_W'(nv_ff);
      magw_in      = div_wneg_in ? NUM_W'(-nw_ff) : NUM_W'(nw_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff    <= 1'b0;
         b2_valid_ff    <= 1'b0;
         b3_valid_ff    <= 1'b0;
         dv_valid_ff[0] <= 1'b0;
      end else if (back_en) begin
         b1_valid_ff    <= q_valid;
         b2_valid_ff    <= b1_valid_ff;
         b3_valid_ff    <= b2_valid_ff;
         dv_valid_ff[0] <= b3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (back_en) begin
         for (int i = 0; i < NUM_PAIRS; i++) begin
            hh_ff[i]   <= hh_in[i];
            hl_ff[i]   <= hl_in[i];
            lh_ff[i]   <= lh_in[i];
            ll_ff[i]   <= ll_in[i];
            prod_ff[i] <= prod_in[i];
         end
         den_ff         <= den_in;
         nv_ff          <= nv_in;
         nw_ff          <= nw_in;
         dv_degen_ff[0] <= div_degen_in;
         dv_vneg_ff[0]  <= div_vneg_in;
         dv_wneg_ff[0]  <= div_wneg_in;
         dv_den_ff[0]   <= NUM_W'(den_ff);
         dv_remv_ff[0]  <= '0;
         dv_remw_ff[0]  <= '0;
         dv_numv_ff[0]  <= {magv_in, {FRAC_BITS{1'b0}}};
         dv_numw_ff[0]  <= {magw_in, {FRAC_BITS{1'b0}}};
      end
   end

   // Restoring division, one quotient bit per stage for both weights.
   for (genvar s = 0; s < NQ_W; s++) begin : g_div
      logic [NUM_W:0]   tv_in, tw_in;
      logic             gev_in, gew_in;
      logic [NUM_W-1:0] remv_in, remw_in;

      always_comb begin
         tv_in   = {dv_remv_ff[s], dv_numv_ff[s][NQ_W-1]};
         tw_in   = {dv_remw_ff[s], dv_numw_ff[s][NQ_W-1]};
         gev_in  = tv_in >= {1'b0, dv_den_ff[s]};
         gew_in  = tw_in >= {1'b0, dv_den_ff[s]};
         remv_in = gev_in ? NUM_W'(tv_in - {1'b0, dv_den_ff[s]}) : tv_in[NUM_W-1:0];
         remw_in = gew_in ? NUM_W'(tw_in - {1'b0, dv_den_ff[s]}) : tw_in[NUM_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[s+1] <= 1'b0;
         end else if (back_en) begin
            dv_valid_ff[s+1] <= dv_valid_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (back_en) begin
            dv_degen_ff[s+1] <= dv_degen_ff[s];
            dv_vneg_ff[s+1]  <= dv_vneg_ff[s];
            dv_wneg_ff[s+1]  <= dv_wneg_ff[s];
            dv_den_ff[s+1]   <= dv_den_ff[s];
            dv_remv_ff[s+1]  <= remv_in;
            dv_remw_ff[s+1]  <= remw_in;
            dv_numv_ff[s+1]  <= {dv_numv_ff[s][NQ_W-2:0], gev_in};
            dv_numw_ff[s+1]  <= {dv_numw_ff[s][NQ_W-2:0], gew_in};
         end
      end
   end

   // Apply the signs of the numerators to the truncated quotients.
   always_comb begin
      v_in = dv_vneg_ff[NQ_W] ? -QS_W'(dv_numv_ff[NQ_W]) : QS_W'(dv_numv_ff[NQ_W]);
      w_in = dv_wneg_ff[NQ_W] ? -QS_W'(dv_numw_ff[NQ_W]) : QS_W'(dv_numw_ff[NQ_W]);
   end

   // Weight of vertex A, then saturation; a degenerate triangle gives zero weights.
   always_comb begin
      u_full = WEIGHT_ONE - U_W'(v_ff) - U_W'(w_ff);
      if (s1_degen_ff) begin
         rsp_data_in.weight_u   = '0;
         rsp_data_in.weight_v   = '0;
         rsp_data_in.weight_w   = '0;
         rsp_data_in.degenerate = 1'b1;
      end else begin
         rsp_data_in.weight_u   = sat_out(u_full);
         rsp_data_in.weight_v   = sat_out(U_W'(v_ff));
         rsp_data_in.weight_w   = sat_out(U_W'(w_ff));
         rsp_data_in.degenerate = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (back_en) begin
         s1_valid_ff  <= dv_valid_ff[NQ_W];
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (back_en) begin
         s1_degen_ff <= dv_degen_ff[NQ_W];
         v_ff        <= v_in;
         w_ff        <= w_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

/* hdl/triangle_barycentric_weights.sv */
// Top level of the triangle barycentric weight block: configuration registers and pipelines.
//
// Usage: write vertices A, B and C through the csr_ port (index 0, 1, 2; packed signed
// x, y, z with z on top) while no item is in flight. Each point item offered on the req_
// channel yields one item on the rsp_ channel with weights u, v, w (signed, 16 fraction
// bits, saturated to 24 bits) and a degenerate flag, set with zero weights when the
// triangle has no area.
// An item is taken on a clock edge with valid high and stall low, on either channel.
// Throughput is one item per cycle while neither channel stalls. An item passes 99 register
// stages at the default widths: 3 front stages, 1 queue entry and NUM_W + FRAC_BITS + 6
// back stages. The depth is set by the division, which resolves one quotient bit per
// stage.
// When the receiver stalls, the back pipeline holds, the queue fills and the front then
// raises req_stall; nothing is dropped. The result register keeps its item stable.
// Reset is synchronous and active high; it clears the vertices to zero (a degenerate
// triangle), empties the queue and drops all items in flight.
module triangle_barycentric_weights (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  tbw_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output tbw_pkg::rsp_type                  rsp_data,
   input  logic                              csr_write_en,
   input  logic [tbw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tbw_pkg::VERT_W-1:0]        csr_wdata
);
   import tbw_pkg::*;

   logic [VERT_W-1:0] vertex_a_ff, vertex_a_in;
   logic [VERT_W-1:0] vertex_b_ff, vertex_b_in;
   logic [VERT_W-1:0] vertex_c_ff, vertex_c_in;

   logic     q_push, q_full, q_pop, q_valid;
   dots_type q_wdata, q_rdata;

   // Register write decode; indexes beyond the list are ignored.
   always_comb begin
      vertex_a_in = vertex_a_ff;
      vertex_b_in = vertex_b_ff;
      vertex_c_in = vertex_c_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_VERTEX_A: vertex_a_in = csr_wdata;
            CSR_VERTEX_B: vertex_b_in = csr_wdata;
            CSR_VERTEX_C: vertex_c_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_a_ff <= '0;
         vertex_b_ff <= '0;
         vertex_c_ff <= '0;
      end else begin
         vertex_a_ff <= vertex_a_in;
         vertex_b_ff <= vertex_b_in;
         vertex_c_ff <= vertex_c_in;
      end
   end

   tbw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .vertex_a  (vertex_a_ff),
      .vertex_b  (vertex_b_ff),
      .vertex_c  (vertex_c_ff),
      .q_push    (q_push),
      .q_data    (q_wdata),
      .q_full    (q_full)
   );

   tbw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_rdata)
   );

   tbw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_rdata),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* tb/triangle_barycentric_weights_check.sv */
// Checker that predicts the barycentric weights of each accepted point and compares results.
`timescale 1ns / 100ps

module triangle_barycentric_weights_check (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  tbw_pkg::req_type              req_data,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  tbw_pkg::rsp_type              rsp_data,
   input  logic                          csr_write_en,
   input  logic [tbw_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tbw_pkg::VERT_W-1:0]    csr_wdata,
   output int                            error_count,
   output int                            pending_count
);
   import tbw_pkg::*;

   logic [VERT_W-1:0] vert_a, vert_b, vert_c;
   rsp_type weights_due[$];

   // Coordinate k of a packed vertex, sign extended.
   function automatic logic signed [127:0] axis_of(logic [VERT_W-1:0] v, int k);
      logic signed [COORD_BITS-1:0] c;
      c = v[k*COORD_BITS +: COORD_BITS];
      return 128'(c);
   endfunction

   // Clamp to the output range.
   function automatic logic signed [OUT_BITS-1:0] clamp_weight(logic signed [127:0] x);
      logic signed [127:0] hi, lo;
      hi = (128'sd1 <<< (OUT_BITS - 1)) - 1;
      lo = -hi - 1;
      if (x > hi) return hi[OUT_BITS-1:0];
      if (x < lo) return lo[OUT_BITS-1:0];
      return x[OUT_BITS-1:0];
   endfunction

   // Truncating fixed point quotient; den is positive.
   function automatic logic signed [127:0] frac_quot(logic signed [127:0] num,
                                                      logic signed [127:0] den);
      logic signed [127:0] mag;
      mag = num < 0 ? -num : num;
      mag = (mag <<< FRAC_BITS) / den;
      return num < 0 ? -mag : mag;
   endfunction

   // Weights of one point against the current triangle.
   function automatic rsp_type weigh_point(req_type pt);
      logic signed [127:0] e0[3], e1[3], p[3], pc[3];
      logic signed [127:0] d00, d01, d11, d20, d21, den, v, w;
      rsp_type r;
      pc[0] = 128'(pt.point_x);
      pc[1] = 128'(pt.point_y);
      pc[2] = 128'(pt.point_z);
      d00 = 0; d01 = 0; d11 = 0; d20 = 0; d21 = 0;
      for (int k = 0; k < 3; k++) begin
         e0[k] = axis_of(vert_b, k) - axis_of(vert_a, k);
         e1[k] = axis_of(vert_c, k) - axis_of(vert_a, k);
         p[k]  = pc[k] - axis_of(vert_a, k);
         d00 += e0[k] * e0[k];
         d01 += e0[k] * e1[k];
         d11 += e1[k] * e1[k];
         d20 += p[k] * e0[k];
         d21 += p[k] * e1[k];
      end
      den = d00 * d11 - d01 * d01;
      r = '0;
      if (den <= 0) begin
         r.degenerate = 1'b1;
      end else begin
         v = frac_quot(d11 * d20 - d01 * d21, den);
         w = frac_quot(d00 * d21 - d01 * d20, den);
         r.weight_u = clamp_weight((128'sd1 <<< FRAC_BITS) - v - w);
         r.weight_v = clamp_weight(v);
         r.weight_w = clamp_weight(w);
      end
      return r;
   endfunction

   assign pending_count = weights_due.size();

   // Track registers, predict on accepted points and compare accepted results.
   always @(posedge clock) begin
      rsp_type want;
      int errs;
      errs = 0;
      if (reset) begin
         vert_a <= '0;
         vert_b <= '0;
         vert_c <= '0;
         weights_due.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_VERTEX_A: vert_a <= csr_wdata;
               CSR_VERTEX_B: vert_b <= csr_wdata;
               CSR_VERTEX_C: vert_c <= csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            weights_due.push_back(weigh_point(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            if (weights_due.size() == 0) begin
               $error("unexpected result item %h", rsp_data);
               errs++;
            end else begin
               want = weights_due.pop_front();
               if (rsp_data.weight_u !== want.weight_u) begin
                  $error("weight_u: expected %0d, got %0d", want.weight_u, rsp_data.weight_u);
                  errs++;
               end
               if (rsp_data.weight_v !== want.weight_v) begin
                  $error("weight_v: expected %0d, got %0d", want.weight_v, rsp_data.weight_v);
                  errs++;
               end
               if (rsp_data.weight_w !== want.weight_w) begin
                  $error("weight_w: expected %0d, got %0d", want.weight_w, rsp_data.weight_w);
                  errs++;
               end
               if (rsp_data.degenerate !== want.degenerate) begin
                  $error("degenerate: expected %0d, got %0d", want.degenerate,
                         rsp_data.degenerate);
                  errs++;
               end
            end
         end
         if (errs != 0) begin
            error_count <= error_count + errs;
         end
      end
   end

   initial error_count = 0;

endmodule

/* tb/triangle_barycentric_weights_test.sv */
// Top of the barycentric weight testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module triangle_barycentric_weights_test;
   import tbw_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 150;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_VERTEX_A;
   logic [VERT_W-1:0] csr_wdata = '0;
   int error_count, pending_count;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;

   triangle_barycentric_weights dut (.*);
   triangle_barycentric_weights_check checker_inst (.*);

   always #4 clock = ~clock;

   // Receiver stalls at random.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Watchdog on cycles with no accepted item.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // Offer one point, idle at random first, and wait for acceptance.
   // Valid stays high afterwards until the next point or idle cycle replaces it.
   task automatic send_point(req_type pt);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= pt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Write one vertex once all results are in and the pipe is empty.
   task automatic write_vertex(logic [CSR_IDX_W-1:0] idx, logic [VERT_W-1:0] v);
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   function automatic logic [VERT_W-1:0] pack_vertex(int x, int y, int z);
      return {16'(z), 16'(y), 16'(x)};
   endfunction

   function automatic logic [15:0] rand_coord(int span);
      if (span == 0) return 16'($urandom);
      return 16'($urandom_range(2 * span) - span);
   endfunction

   function automatic req_type rand_point(int span);
      req_type p;
      p.point_x = rand_coord(span);
      p.point_y = rand_coord(span);
      p.point_z = rand_coord(span);
      return p;
   endfunction

   task automatic write_triangle(logic [VERT_W-1:0] a, logic [VERT_W-1:0] b,
                                 logic [VERT_W-1:0] c);
      write_vertex(CSR_VERTEX_A, a);
      write_vertex(CSR_VERTEX_B, b);
      write_vertex(CSR_VERTEX_C, c);
   endtask

   initial begin
      int span;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Registers at reset give a degenerate triangle.
      send_point('{16'sh7fff, 16'sh8000, 16'sh0000});
      send_point('{16'sh8000, 16'sh7fff, 16'shffff});

      // Small right triangle: vertices and far points that saturate.
      write_triangle(pack_vertex(0, 0, 0), pack_vertex(1, 0, 0), pack_vertex(0, 1, 0));
      send_point('{16'sd0, 16'sd0, 16'sd0});
      send_point('{16'sd1, 16'sd0, 16'sd0});
      send_point('{16'sd0, 16'sd1, 16'sd0});
      send_point('{16'sh7fff, 16'sh7fff, 16'sh7fff});
      send_point('{16'sh8000, 16'sh8000, 16'sh8000});
      send_point('{16'sh8000, 16'sh7fff, 16'sh0001});
      send_point('{16'sh5555, 16'shaaaa, 16'sh5555});

      // Extreme vertices.
      write_triangle({16'h8000, 16'h8000, 16'h8000}, {16'h7fff, 16'h8000, 16'h7fff},
                     {16'h8000, 16'h7fff, 16'h7fff});
      send_point('{16'sh0000, 16'sh0000, 16'sh0000});
      send_point('{16'sh7fff, 16'sh7fff, 16'sh7fff});
      send_point('{16'sh8000, 16'sh8000, 16'sh8000});
      send_point('{16'shaaaa, 16'sh5555, 16'shffff});

      // Collinear vertices.
      write_triangle(pack_vertex(1, 2, 3), pack_vertex(2, 4, 6), pack_vertex(-3, -6, -9));
      send_point('{16'sd5, 16'sd5, 16'sd5});
      send_point('{16'sh7fff, 16'sh8000, 16'sh7fff});

      // Random phases: triangle, idling and stalling mode, then points near and far.
      for (int phase = 0; phase < 16; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 64; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 64; end
            default: begin send_idle_pct = 18; stall_pct = 18; end
         endcase
         span = (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 200 : 5000;
         if (phase == 7) begin
            write_triangle({16'h1234, 16'h0000, 16'h0000}, pack_vertex(0, 0, 0),
                           pack_vertex(0, 0, 0));
         end else begin
            write_triangle({rand_coord(span), rand_coord(span), rand_coord(span)},
                           {rand_coord(span), rand_coord(span), rand_coord(span)},
                           {rand_coord(span), rand_coord(span), rand_coord(span)});
         end
         for (int n = 0; n < 40; n++) begin
            send_point(rand_point($urandom_range(1) ? 2 * span + 10 : 0));
         end
      end

      // Drain and give the verdict.
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
